// ===== rtl/core/cpl_pkg.sv =====
// Shared types and constants for the color palette leader cluster.
// Used by cpl_l1_unit, cpl_seq and color_palette_leader_cluster; no dependencies.

package cpl_pkg;

    // Palette geometry
    localparam int PALETTE_SIZE = 16;
    localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);

    // Field widths
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int THR_W   = 10;
    localparam int LIM_W   = 4;
    localparam int OIDX_W  = 4;
    localparam int OCNT_W  = 5;

    // Register indexes and reset values
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(150);
    localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(5);

    // Packed pixel: blue low, red high
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    // Result handed from the sequencer to the output stage
    typedef struct packed {
        logic [OIDX_W-1:0] entry_index;
        logic              created;
        logic              dropped;
        logic [CNT_W-1:0]  entry_count;
        logic              image_done;
    } t_result;

endpackage

// ===== rtl/core/color_palette_leader_cluster.sv =====
// Top level of the color palette leader cluster: config registers, output stage.
// Depends on cpl_pkg and cpl_seq.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one BGR pixel and a
//   last-pixel flag per request. Output channel (o_out_valid / i_out_stall)
//   returns one result per pixel: matched or new entry index, created and
//   dropped flags, entry count, many-colors flag and image-done flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes index 0 = distance
//   threshold, index 1 = color limit (low 4 bits of i_cfg_data); always ready.
//   Write config only while no pixel is in flight.
// Timing:
//   A pixel is checked against stored entries in insertion order, one entry
//   per cycle through the single distance unit behind a registered memory
//   read. The scan ends at the first match or after the last entry in use,
//   and is skipped when the palette is empty. o_in_stall is high while
//   an item is in work. The result sits in an output register, so the next
//   pixel is taken while it waits; a stalled result blocks only the commit
//   of the following pixel.
// Reset: synchronous, active low; palette empty, threshold 150, limit 5.
//   No memory clearing pass is needed.

module color_palette_leader_cluster (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel requests
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_red,
    input  logic                          i_last_pixel,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [3:0]                    o_entry_index,
    output logic                          o_created,
    output logic                          o_dropped,
    output logic [4:0]                    o_entry_count,
    output logic                          o_many_colors,
    output logic                          o_image_done,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [9:0]                    i_cfg_data
);

    logic [cpl_pkg::THR_W-1:0] r_threshold;
    logic [cpl_pkg::LIM_W-1:0] r_limit;

    logic                      r_out_valid;
    logic [3:0]                r_entry_index;
    logic                      r_created;
    logic                      r_dropped;
    logic [4:0]                r_entry_count;
    logic                      r_many_colors;
    logic                      r_image_done;

    logic                      w_busy;
    logic                      w_res_valid;
    logic                      w_res_free;
    logic                      w_load;
    cpl_pkg::t_result          w_res;
    cpl_pkg::t_color           w_pixel;

    assign w_pixel.blue  = i_blue;
    assign w_pixel.green = i_green;
    assign w_pixel.red   = i_red;

    cpl_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !w_busy),
        .i_pixel     (w_pixel),
        .i_last      (i_last_pixel),
        .i_threshold (r_threshold),
        .i_res_free  (w_res_free),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign o_in_stall = w_busy;
    assign o_cfg_ready = 1'b1;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cpl_pkg::THRESHOLD_RST;
            r_limit     <= cpl_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cpl_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                cpl_pkg::REG_LIMIT:     r_limit     <= i_cfg_data[cpl_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: free when empty or being taken
    assign w_res_free = !r_out_valid || !i_out_stall;
    assign w_load     = w_res_valid && w_res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry_index <= w_res.entry_index;
            r_created     <= w_res.created;
            r_dropped     <= w_res.dropped;
            r_entry_count <= 5'(w_res.entry_count);
            r_many_colors <= (32'(w_res.entry_count) > 32'(r_limit));
            r_image_done  <= w_res.image_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_index = r_entry_index;
    assign o_created     = r_created;
    assign o_dropped     = r_dropped;
    assign o_entry_count = r_entry_count;
    assign o_many_colors = r_many_colors;
    assign o_image_done  = r_image_done;

endmodule

// ===== rtl/core/cpl_l1_unit.sv =====
// Shared L1 distance unit: |db|+|dg|+|dr| against the threshold.
// Depends on cpl_pkg for the color type and widths.

module cpl_l1_unit (
    input  cpl_pkg::t_color                 i_entry,
    input  cpl_pkg::t_color                 i_pixel,
    input  logic [cpl_pkg::THR_W-1:0]       i_threshold,
    output logic                            o_hit
);

    logic [cpl_pkg::CH_W-1:0]  w_db;
    logic [cpl_pkg::CH_W-1:0]  w_dg;
    logic [cpl_pkg::CH_W-1:0]  w_dr;
    logic [cpl_pkg::THR_W-1:0] w_dist;

    // Per-channel absolute differences
    assign w_db = (i_entry.blue  > i_pixel.blue)  ? i_entry.blue  - i_pixel.blue
                                                  : i_pixel.blue  - i_entry.blue;
    assign w_dg = (i_entry.green > i_pixel.green) ? i_entry.green - i_pixel.green
                                                  : i_pixel.green - i_entry.green;
    assign w_dr = (i_entry.red   > i_pixel.red)   ? i_entry.red   - i_pixel.red
                                                  : i_pixel.red   - i_entry.red;

    // Sum fits in 10 bits (max 765)
    assign w_dist = cpl_pkg::THR_W'(w_db) + cpl_pkg::THR_W'(w_dg) + cpl_pkg::THR_W'(w_dr);

    assign o_hit = (w_dist < i_threshold);

endmodule

// ===== rtl/core/cpl_seq.sv =====
// Scan sequencer: palette memory, entry count and first-match search.
// Depends on cpl_pkg and cpl_l1_unit (one distance check per cycle).

module cpl_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  cpl_pkg::t_color              i_pixel,
    input  logic                         i_last,
    input  logic [cpl_pkg::THR_W-1:0]    i_threshold,
    input  logic                         i_res_free,
    output logic                         o_busy,
    output logic                         o_res_valid,
    output cpl_pkg::t_result             o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [cpl_pkg::CNT_W-1:0] FULL = cpl_pkg::CNT_W'(cpl_pkg::PALETTE_SIZE);

    logic [1:0]                  r_state, n_state;
    logic [cpl_pkg::CNT_W-1:0]   r_used, n_used;
    logic [cpl_pkg::CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic                        r_cmp_valid, n_cmp_valid;
    logic [cpl_pkg::IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic                        r_match, n_match;
    logic [cpl_pkg::IDX_W-1:0]   r_hit_idx, n_hit_idx;
    cpl_pkg::t_color             r_pixel;
    logic                        r_last;

    cpl_pkg::t_color             r_mem [cpl_pkg::PALETTE_SIZE];
    cpl_pkg::t_color             r_rd_data;

    logic                        w_hit;
    logic                        w_rd_en;
    logic                        w_create;
    logic                        w_commit;
    logic [cpl_pkg::CNT_W-1:0]   w_used_after;
    logic [cpl_pkg::IDX_W-1:0]   w_res_idx;

    // Palette memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_commit && w_create) begin
            r_mem[r_used[cpl_pkg::IDX_W-1:0]] <= r_pixel;
        end
        r_rd_data <= r_mem[r_rd_idx[cpl_pkg::IDX_W-1:0]];
    end

    // Distance check on the entry read last cycle
    cpl_l1_unit u_l1 (
        .i_entry     (r_rd_data),
        .i_pixel     (r_pixel),
        .i_threshold (i_threshold),
        .o_hit       (w_hit)
    );

    // Result of the finished scan
    assign w_create     = !r_match && (r_used < FULL);
    assign w_used_after = w_create ? r_used + 1'b1 : r_used;
    assign w_res_idx    = r_match  ? r_hit_idx
                        : w_create ? r_used[cpl_pkg::IDX_W-1:0]
                        : '0;
    assign w_commit     = (r_state == S_DONE) && i_res_free;
    assign w_rd_en      = (r_state == S_SCAN) && (r_rd_idx < r_used);

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    always_comb begin
        o_res.entry_index = cpl_pkg::OIDX_W'(w_res_idx);
        o_res.created     = w_create;
        o_res.dropped     = !r_match && !w_create;
        o_res.entry_count = w_used_after;
        o_res.image_done  = r_last;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_rd_idx    = r_rd_idx;
        n_cmp_valid = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_match     = r_match;
        n_hit_idx   = r_hit_idx;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rd_idx = '0;
                    n_match  = 1'b0;
                    n_state  = (r_used == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // issue next read while checking the previous one
                n_cmp_valid = w_rd_en;
                n_cmp_idx   = r_rd_idx[cpl_pkg::IDX_W-1:0];
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_cmp_valid && w_hit) begin
                    n_match     = 1'b1;
                    n_hit_idx   = r_cmp_idx;
                    n_cmp_valid = 1'b0;
                    n_state     = S_DONE;
                end else if (r_cmp_valid &&
                             (cpl_pkg::CNT_W'(r_cmp_idx) == r_used - 1'b1)) begin
                    n_cmp_valid = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_used  = r_last ? '0 : w_used_after;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_match     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rd_idx    <= n_rd_idx;
            r_cmp_valid <= n_cmp_valid;
            r_match     <= n_match;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_hit_idx <= n_hit_idx;
        if (i_start && (r_state == S_IDLE)) begin
            r_pixel <= i_pixel;
            r_last  <= i_last;
        end
    end

    // Checks
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL)
        else $error("palette count above capacity");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_match) |-> (cpl_pkg::CNT_W'(r_hit_idx) < r_used))
        else $error("match reported on an unused entry");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_last) |=> (r_used == '0))
        else $error("palette not cleared after last pixel");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (r_state == S_SCAN))
        else $error("compare pending outside scan");

    a_grow_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> (r_used == $past(r_used)))
        else $error("palette count changed outside commit");

endmodule

// ===== tb/tb_color_palette_leader_cluster.sv =====
// Self-checking bench for color_palette_leader_cluster: directed table, then random images.
// Results are checked against a palette predictor in this file, or typed-in results for table rows.

module tb_color_palette_leader_cluster;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 400;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_BASES      = 18;

    // One result as the block reports it
    typedef struct packed {
        logic [3:0] entry_index;
        logic       created;
        logic       dropped;
        logic [4:0] entry_count;
        logic       many_colors;
        logic       image_done;
    } t_palette_res;

    // One row of the directed table: a register write or a run of pixels
    typedef struct {
        bit              is_reg;
        logic            reg_idx;
        logic [9:0]      reg_val;
        int              reps;
        cpl_pkg::t_color px;
        bit              last;
        bit              typed;
        t_palette_res    res;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_blue = '0;
    logic [7:0] i_green = '0;
    logic [7:0] i_red = '0;
    logic       i_last_pixel = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [3:0] o_entry_index;
    logic       o_created;
    logic       o_dropped;
    logic [4:0] o_entry_count;
    logic       o_many_colors;
    logic       o_image_done;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = 1'b0;
    logic [9:0] i_cfg_data = '0;

    // Predictor state
    cpl_pkg::t_color palette_mem [cpl_pkg::PALETTE_SIZE];
    int              palette_fill;
    logic [9:0]      thresh_reg;
    logic [3:0]      limit_reg;

    t_palette_res pending_results[$];
    t_dir_row     dir_rows[$];

    int pixels_sent, results_seen, mismatches, reg_writes;
    int created_seen, dropped_seen, images_seen;
    int idle_cycles;
    int burst_left, gap_max;
    int stall_run;
    logic [15:0] stall_cyc;

    color_palette_leader_cluster DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_index (o_entry_index),
        .o_created     (o_created),
        .o_dropped     (o_dropped),
        .o_entry_count (o_entry_count),
        .o_many_colors (o_many_colors),
        .o_image_done  (o_image_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Leader clustering: first stored color within the threshold wins, else append, or drop when full
    function automatic t_palette_res classify_pixel(cpl_pkg::t_color px, bit last);
        t_palette_res r;
        bit hit;
        int db, dg, dr;
        r   = '0;
        hit = 1'b0;
        for (int k = 0; k < palette_fill; k++) begin
            db = int'(palette_mem[k].blue)  - int'(px.blue);
            dg = int'(palette_mem[k].green) - int'(px.green);
            dr = int'(palette_mem[k].red)   - int'(px.red);
            if (db < 0) db = -db;
            if (dg < 0) dg = -dg;
            if (dr < 0) dr = -dr;
            if (!hit && (db + dg + dr) < int'(thresh_reg)) begin
                hit = 1'b1;
                r.entry_index = 4'(k);
            end
        end
        if (!hit) begin
            if (palette_fill < cpl_pkg::PALETTE_SIZE) begin
                r.entry_index = 4'(palette_fill);
                palette_mem[palette_fill] = px;
                palette_fill++;
                r.created = 1'b1;
            end else begin
                r.dropped = 1'b1;
            end
        end
        r.entry_count = 5'(palette_fill);
        r.many_colors = (palette_fill > int'(limit_reg));
        r.image_done  = last;
        if (last)
            palette_fill = 0;
        return r;
    endfunction

    function automatic t_dir_row pixel_row(int reps, logic [7:0] b, logic [7:0] g,
                                           logic [7:0] r, bit last);
        t_dir_row row;
        row = '{default: '0};
        row.reps = reps;
        row.px   = '{red: r, green: g, blue: b};
        row.last = last;
        return row;
    endfunction

    // Pixel row whose result is typed in by hand
    function automatic t_dir_row checked_row(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                             bit last, int idx, bit cr, bit dr, int cnt,
                                             bit many);
        t_dir_row row;
        row = pixel_row(1, b, g, r, last);
        row.typed = 1'b1;
        row.res   = '{entry_index: 4'(idx), created: cr, dropped: dr,
                      entry_count: 5'(cnt), many_colors: many, image_done: last};
        return row;
    endfunction

    function automatic t_dir_row reg_row(logic idx, int val);
        t_dir_row row;
        row = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = 10'(val);
        return row;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(t_dir_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic logic [7:0] jitter_chan(logic [7:0] base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Register write, only once every pixel in flight has reported
    task automatic write_reg(logic idx, logic [9:0] val);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == cpl_pkg::REG_THRESHOLD)
            thresh_reg = val;
        else
            limit_reg = val[3:0];
        reg_writes++;
    endtask

    // One pixel request; valid stays up into the next request unless a gap is due
    task automatic send_pixel(cpl_pkg::t_color px, bit last, bit typed,
                              t_palette_res typed_res);
        t_palette_res r;
        int gap;
        i_cfg_valid  <= 1'b0;
        i_in_valid   <= 1'b1;
        i_blue       <= px.blue;
        i_green      <= px.green;
        i_red        <= px.red;
        i_last_pixel <= last;
        do @(posedge i_clk); while (o_in_stall);
        r = classify_pixel(px, last);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
        pixels_sent++;
        if (gap_max > 0) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, gap_max);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Receiver stall pattern: free, coin flip, long runs, periodic
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cyc   <= '0;
            stall_run   <= 0;
        end else begin
            stall_cyc <= stall_cyc + 1'b1;
            case (stall_cyc[8:7])
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= 1'($urandom_range(0, 1));
                2'd2: begin
                    if (stall_run > 0) begin
                        stall_run   <= stall_run - 1;
                        i_out_stall <= 1'b1;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_run   <= $urandom_range(1, 20);
                        i_out_stall <= 1'b1;
                    end else begin
                        i_out_stall <= 1'b0;
                    end
                end
                default: i_out_stall <= ((stall_cyc % 5) < 2);
            endcase
        end
    end

    // Result checker and idle counter for the watchdog
    always @(posedge i_clk) begin
        t_palette_res got, want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (o_out_valid && !i_out_stall) begin
                got = '{entry_index: o_entry_index, created: o_created,
                        dropped: o_dropped, entry_count: o_entry_count,
                        many_colors: o_many_colors, image_done: o_image_done};
                results_seen++;
                if (o_created) created_seen++;
                if (o_dropped) dropped_seen++;
                if (o_image_done) images_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result %0d: idx=%0d cr=%0b dr=%0b ",
                                  "cnt=%0d mc=%0b done=%0b"},
                                 results_seen, got.entry_index, got.created, got.dropped,
                                 got.entry_count, got.many_colors, got.image_done);
                end else begin
                    want = pending_results.pop_front();
                    if (got.entry_index !== want.entry_index || got.created !== want.created
                            || got.dropped !== want.dropped
                            || got.entry_count !== want.entry_count
                            || got.many_colors !== want.many_colors
                            || got.image_done !== want.image_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: expected idx=%0d cr=%0b dr=%0b ",
                                      "cnt=%0d mc=%0b done=%0b, got idx=%0d cr=%0b dr=%0b ",
                                      "cnt=%0d mc=%0b done=%0b"},
                                     results_seen, want.entry_index, want.created,
                                     want.dropped, want.entry_count, want.many_colors,
                                     want.image_done, got.entry_index, got.created,
                                     got.dropped, got.entry_count, got.many_colors,
                                     got.image_done);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request moving
    initial begin
        do @(posedge i_clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("watchdog: %0d cycles without progress", WATCHDOG_LIMIT);
        $display("tb_color_palette_leader_cluster NOT OK");
        $finish;
    end

    initial begin
        cpl_pkg::t_color bases [MAX_BASES];
        cpl_pkg::t_color px;
        t_palette_res    none;
        int n_bases, img_len, spread, phase_end;
        bit last;

        none         = '0;
        palette_fill = 0;
        thresh_reg   = cpl_pkg::THRESHOLD_RST;
        limit_reg    = cpl_pkg::LIMIT_RST;
        gap_max      = 3;
        burst_left   = 0;

        // Directed table: defaults, full palette, threshold extremes, limit extremes
        add_row(checked_row(8'd0, 8'd0, 8'd0, 1'b0, 0, 1, 0, 1, 0));
        add_row(checked_row(8'd255, 8'd255, 8'd255, 1'b0, 1, 1, 0, 2, 0));
        add_row(checked_row(8'd1, 8'd1, 8'd1, 1'b0, 0, 0, 0, 2, 0));
        add_row(checked_row(8'd255, 8'd255, 8'd255, 1'b1, 1, 0, 0, 2, 0));
        // threshold zero: identical pixels never match, palette fills, then drops
        add_row(reg_row(cpl_pkg::REG_THRESHOLD, 0));
        add_row(pixel_row(16, 8'd0, 8'd0, 8'd0, 1'b0));
        add_row(checked_row(8'd255, 8'd0, 8'd255, 1'b1, 0, 0, 1, 16, 1));
        // widest threshold matches anything; limit zero flags a single entry
        add_row(reg_row(cpl_pkg::REG_LIMIT, 0));
        add_row(reg_row(cpl_pkg::REG_THRESHOLD, 766));
        add_row(checked_row(8'd0, 8'd0, 8'd0, 1'b0, 0, 1, 0, 1, 1));
        add_row(checked_row(8'd255, 8'd255, 8'd255, 1'b1, 0, 0, 0, 1, 1));
        // threshold one: only an exact color matches
        add_row(reg_row(cpl_pkg::REG_THRESHOLD, 1));
        add_row(reg_row(cpl_pkg::REG_LIMIT, 15));
        add_row(checked_row(8'd128, 8'd64, 8'd32, 1'b0, 0, 1, 0, 1, 0));
        add_row(checked_row(8'd128, 8'd64, 8'd33, 1'b1, 1, 1, 0, 2, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_reg)
                write_reg(dir_rows[n].reg_idx, dir_rows[n].reg_val);
            else
                repeat (dir_rows[n].reps)
                    send_pixel(dir_rows[n].px, dir_rows[n].last, dir_rows[n].typed,
                               dir_rows[n].res);
        end

        // Random phases: new settings, then images built around a few base colors
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_reg(cpl_pkg::REG_THRESHOLD, 10'(150));
                1: write_reg(cpl_pkg::REG_THRESHOLD, 10'(766));
                2: write_reg(cpl_pkg::REG_THRESHOLD, 10'(1));
                default: begin
                    case ($urandom_range(0, 4))
                        0: write_reg(cpl_pkg::REG_THRESHOLD, 10'($urandom_range(0, 1023)));
                        1: write_reg(cpl_pkg::REG_THRESHOLD, 10'(0));
                        2: write_reg(cpl_pkg::REG_THRESHOLD, 10'($urandom_range(1, 766)));
                        default: write_reg(cpl_pkg::REG_THRESHOLD,
                                           10'($urandom_range(20, 200)));
                    endcase
                end
            endcase
            case (phase)
                1: write_reg(cpl_pkg::REG_LIMIT, 10'(0));
                2: write_reg(cpl_pkg::REG_LIMIT, 10'(15));
                default: write_reg(cpl_pkg::REG_LIMIT, 10'($urandom_range(0, 15)));
            endcase
            gap_max    = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
            burst_left = 0;
            phase_end  = pixels_sent + RANDOM_PIXELS / NUM_PHASES;

            while (pixels_sent < phase_end) begin
                img_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
                n_bases = $urandom_range(1, MAX_BASES);
                spread  = $urandom_range(0, 60);
                for (int k = 0; k < n_bases; k++)
                    bases[k] = cpl_pkg::t_color'(24'($urandom));
                for (int p = 0; p < img_len; p++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        px = cpl_pkg::t_color'(24'($urandom));
                    end else begin
                        px = bases[$urandom_range(0, n_bases - 1)];
                        px.blue  = jitter_chan(px.blue, spread);
                        px.green = jitter_chan(px.green, spread);
                        px.red   = jitter_chan(px.red, spread);
                    end
                    // occasional early close breaks the image
                    last = (p == img_len - 1) || ($urandom_range(0, 24) == 0);
                    send_pixel(px, last, 1'b0, none);
                end
            end
        end

        // Drain
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0)
            mismatches++;

        $display("covered %0d pixels in %0d images over %0d register writes",
                 pixels_sent, images_seen, reg_writes);
        $display("results %0d: %0d new entries, %0d dropped, %0d mismatches",
                 results_seen, created_seen, dropped_seen, mismatches);
        if (mismatches == 0)
            $display("tb_color_palette_leader_cluster OK");
        else
            $display("tb_color_palette_leader_cluster NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cpl_pkg.sv
rtl/core/cpl_l1_unit.sv
rtl/core/cpl_seq.sv
rtl/core/color_palette_leader_cluster.sv
tb/tb_color_palette_leader_cluster.sv
